// File: design/strip_chart_trace_rasterizer_core_assert.svh
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer assertion macros
// Property shorthands used by the datapath module.
// ---------------------------------------------------------------------------
`ifndef STRIP_CHART_TRACE_RASTERIZER_CORE_ASSERT_SVH
`define STRIP_CHART_TRACE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define SCTR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous active-low reset
`define SCTR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sctr_pkg.sv
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer package
// Field widths, register map, controller states and command/status bundles.
// ---------------------------------------------------------------------------
package sctr_pkg;

  localparam int COL_FIELD_W = 10;
  localparam int VAL_W       = 8;
  localparam int PIX_Y_W     = 6;
  localparam int COLOR_W     = 8;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int MAX_PIXELS  = 64;
  localparam int IDX_W       = 7;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic REG_TRACE_COLOR = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } sctr_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } sctr_cmd_t;

  typedef struct packed {
    logic no_pixels;
    logic out_free;
    logic final_pixel;
  } sctr_stat_t;

endpackage

// File: design/sctr_regs.sv
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer register file
// APB-style port holding the trace color register.
// ---------------------------------------------------------------------------
module sctr_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sctr_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [sctr_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [sctr_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output logic [sctr_pkg::COLOR_W-1:0]       trace_color
);

  logic [sctr_pkg::COLOR_W-1:0] trace_color_r;
  logic                         hit_color;

  assign cfg_pready = 1'b1;
  assign hit_color  = (cfg_paddr[2] == sctr_pkg::REG_TRACE_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_color_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit_color) begin
      trace_color_r <= cfg_pwdata[sctr_pkg::COLOR_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit_color) begin
      cfg_prdata = {{(sctr_pkg::APB_DATA_W - sctr_pkg::COLOR_W){1'b0}}, trace_color_r};
    end
  end

  assign trace_color = trace_color_r;

endmodule

// File: design/sctr_ctrl.sv
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer controller
// Sequences load, run setup and pixel emission for one column request.
// ---------------------------------------------------------------------------
module sctr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output sctr_pkg::sctr_cmd_t   cmd,
  input  sctr_pkg::sctr_stat_t  stat
);

  sctr_pkg::sctr_state_t state_r;
  sctr_pkg::sctr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sctr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sctr_pkg::ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = sctr_pkg::ST_SETUP;
        end
      end
      sctr_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.no_pixels ? sctr_pkg::ST_IDLE : sctr_pkg::ST_EMIT;
      end
      sctr_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.final_pixel) begin
            state_nxt = sctr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sctr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/sctr_datapath.sv
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer datapath
// Row scaling, step split, pixel row walk and the output pixel register.
// ---------------------------------------------------------------------------
`include "strip_chart_trace_rasterizer_core_assert.svh"

module sctr_datapath #(
  parameter int TRACE_HEIGHT = 64,
  parameter int COLUMN_BITS  = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sctr_pkg::sctr_cmd_t                   cmd,
  output sctr_pkg::sctr_stat_t                  stat,
  input  logic [sctr_pkg::COL_FIELD_W-1:0]      in_column,
  input  logic [sctr_pkg::VAL_W-1:0]            in_sample_value,
  input  logic                                  in_sample_present,
  input  logic                                  in_range_start,
  input  logic                                  in_range_end,
  input  logic                                  in_left_present,
  input  logic [sctr_pkg::VAL_W-1:0]            in_left_value,
  input  logic [sctr_pkg::COLOR_W-1:0]          trace_color,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [sctr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int ROW_W       = $clog2(TRACE_HEIGHT);
  localparam int SCALE_DIV   = 256 / TRACE_HEIGHT;
  localparam int SCALE_SHIFT = 16;
  localparam int SCALE_MUL   = ((1 << SCALE_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
  localparam int PROD_W      = sctr_pkg::VAL_W + SCALE_SHIFT + 1;
  localparam int CNT_W       = ROW_W + 1;
  localparam int SUM_W       = ROW_W + 2;
  localparam int CMP_W       = (SUM_W > sctr_pkg::IDX_W) ? SUM_W : sctr_pkg::IDX_W;
  localparam logic [sctr_pkg::VAL_W:0] ROW_MAX = (sctr_pkg::VAL_W + 1)'(TRACE_HEIGHT - 1);

  function automatic logic [ROW_W-1:0] scale_row(input logic [sctr_pkg::VAL_W-1:0] v);
    logic [PROD_W-1:0]          prod;
    logic [sctr_pkg::VAL_W:0]   q;
    prod = PROD_W'(v) * PROD_W'(SCALE_MUL);
    q    = {1'b0, prod[SCALE_SHIFT +: sctr_pkg::VAL_W]};
    return ROW_W'(ROW_MAX - q);
  endfunction

  // trace state
  logic [ROW_W-1:0]              prev_row_r;
  logic                          seg_restart_r;

  // loaded column
  logic [COLUMN_BITS-1:0]        col_r;
  logic [COLUMN_BITS-1:0]        prev_col_r;
  logic [ROW_W-1:0]              y0_r;
  logic [ROW_W-1:0]              y1_r;
  logic                          start_r;
  logic                          rend_r;
  logic                          present_r;

  // run setup
  logic [CNT_W-1:0]              cnt_a_r;
  logic [ROW_W-1:0]              row_b_r;
  logic                          up_r;
  logic [sctr_pkg::IDX_W-1:0]    total_r;
  logic [sctr_pkg::IDX_W-1:0]    idx_r;
  logic [ROW_W-1:0]              row_r;

  // output pixel register
  logic                          out_tvalid_r;
  logic [sctr_pkg::COL_FIELD_W-1:0] out_x_r;
  logic [sctr_pkg::PIX_Y_W-1:0]  out_y_r;
  logic [sctr_pkg::COLOR_W-1:0]  out_color_r;
  logic                          out_last_r;

  // load stage
  logic [COLUMN_BITS+sctr_pkg::COL_FIELD_W-1:0] col_ext;
  logic [COLUMN_BITS-1:0]        col_in;
  logic                          start_in;
  logic                          use_left_in;
  logic [ROW_W-1:0]              y1_in;
  logic [ROW_W-1:0]              y0_in;

  assign col_ext     = {{COLUMN_BITS{1'b0}}, in_column};
  assign col_in      = col_ext[COLUMN_BITS-1:0];
  assign start_in    = in_range_start | seg_restart_r;
  assign use_left_in = in_range_start & in_left_present & (col_in != '0);
  assign y1_in       = scale_row(in_sample_value);
  assign y0_in       = start_in ? scale_row(use_left_in ? in_left_value : in_sample_value)
                                : prev_row_r;

  // setup stage
  logic                          up;
  logic [ROW_W-1:0]              d;
  logic [CNT_W-1:0]              half_up;
  logic [CNT_W-1:0]              half_dn;
  logic [CNT_W-1:0]              cnt_a;
  logic [CNT_W-1:0]              cnt_b;
  logic [SUM_W-1:0]              cnt_sum;
  logic [sctr_pkg::IDX_W-1:0]    total;
  logic [ROW_W-1:0]              row_b;

  always_comb begin
    up      = (y1_r > y0_r);
    d       = up ? (y1_r - y0_r) : (y0_r - y1_r);
    half_up = ({1'b0, d} + CNT_W'(1)) >> 1;
    half_dn = {1'b0, d} >> 1;
    if (start_r) begin
      cnt_a = '0;
    end else if (d == '0) begin
      cnt_a = CNT_W'(1);
    end else begin
      cnt_a = half_up;
    end
    cnt_b   = rend_r ? '0 : (half_dn + CNT_W'(1));
    cnt_sum = {1'b0, cnt_a} + {1'b0, cnt_b};
    if (!present_r) begin
      total = '0;
    end else if (CMP_W'(cnt_sum) > CMP_W'(sctr_pkg::MAX_PIXELS)) begin
      total = sctr_pkg::IDX_W'(sctr_pkg::MAX_PIXELS);
    end else begin
      total = sctr_pkg::IDX_W'(cnt_sum);
    end
    row_b = up ? (y0_r + ROW_W'(half_up)) : (y0_r - ROW_W'(half_up));
  end

  // emit stage
  logic [sctr_pkg::IDX_W-1:0]    idx_inc;
  logic                          in_prev_col;
  logic                          end_of_a;
  logic [ROW_W+sctr_pkg::PIX_Y_W-1:0] row_ext;
  logic [COLUMN_BITS+sctr_pkg::COL_FIELD_W-1:0] x_ext;

  assign idx_inc     = idx_r + 1'b1;
  assign in_prev_col = (CMP_W'(idx_r) < CMP_W'(cnt_a_r));
  assign end_of_a    = (CMP_W'(idx_inc) == CMP_W'(cnt_a_r));
  assign row_ext     = {{sctr_pkg::PIX_Y_W{1'b0}}, row_r};
  assign x_ext       = {{sctr_pkg::COL_FIELD_W{1'b0}}, (in_prev_col ? prev_col_r : col_r)};

  assign stat.no_pixels   = (total == '0);
  assign stat.out_free    = !out_tvalid_r || out_tready;
  assign stat.final_pixel = (idx_inc == total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r    <= '0;
      seg_restart_r <= 1'b1;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (in_sample_present) begin
          prev_row_r <= y1_in;
        end
        seg_restart_r <= !in_sample_present;
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r      <= col_in;
      prev_col_r <= col_in - 1'b1;
      y0_r       <= y0_in;
      y1_r       <= y1_in;
      start_r    <= start_in;
      rend_r     <= in_range_end;
      present_r  <= in_sample_present;
    end
    if (cmd.setup) begin
      cnt_a_r <= cnt_a;
      row_b_r <= row_b;
      up_r    <= up;
      total_r <= total;
      idx_r   <= '0;
      row_r   <= (cnt_a == '0) ? row_b : y0_r;
    end
    if (cmd.emit) begin
      out_x_r     <= x_ext[sctr_pkg::COL_FIELD_W-1:0];
      out_y_r     <= row_ext[sctr_pkg::PIX_Y_W-1:0];
      out_color_r <= trace_color;
      out_last_r  <= stat.final_pixel;
      idx_r       <= idx_inc;
      if (end_of_a) begin
        row_r <= row_b_r;
      end else begin
        row_r <= up_r ? (row_r + 1'b1) : (row_r - 1'b1);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_color_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  `SCTR_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, (!out_tvalid_r || out_tready), "pixel register overwritten")
  `SCTR_ASSERT_NOW(a_emit_bound, clk, rst_n, cmd.emit, (idx_r < total_r), "pixel index past run length")
  `SCTR_ASSERT_NEXT(a_emit_shown, clk, rst_n, cmd.emit, out_tvalid_r, "emitted pixel not presented")

endmodule

// File: design/strip_chart_trace_rasterizer_core.sv
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer core
// Flow: a column request is loaded, its run is set up, then its N pixels are
//   emitted, N = pixels caused (0 to 64), one pixel per cycle through the single
//   pixel output register when out_tready holds; no new column request is accepted until the run is done.
// Reset: synchronous active-low; clears trace color and previous row, sets the
//   restart flag; in_tready stays low while rst_n is low.
// ---------------------------------------------------------------------------
module strip_chart_trace_rasterizer_core #(
  parameter int TRACE_HEIGHT = 64,
  parameter int COLUMN_BITS  = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // column[9:0], sample_value[17:10], range_start[18], left_present[19],
  // left_value[27:20], zero pad[31:28]
  input  logic [sctr_pkg::IN_DATA_W-1:0]     in_tdata,
  // sample_present[0]
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_x[9:0], pixel_y[15:10], pixel_color[23:16]
  output logic [sctr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sctr_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [sctr_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [sctr_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  sctr_pkg::sctr_cmd_t           cmd;
  sctr_pkg::sctr_stat_t          stat;
  logic [sctr_pkg::COLOR_W-1:0]  trace_color;

  sctr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .trace_color (trace_color)
  );

  sctr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sctr_datapath #(
    .TRACE_HEIGHT (TRACE_HEIGHT),
    .COLUMN_BITS  (COLUMN_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_column         (in_tdata[9:0]),
    .in_sample_value   (in_tdata[17:10]),
    .in_sample_present (in_tuser),
    .in_range_start    (in_tdata[18]),
    .in_range_end      (in_tlast),
    .in_left_present   (in_tdata[19]),
    .in_left_value     (in_tdata[27:20]),
    .trace_color       (trace_color),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast)
  );

endmodule

// File: dv/strip_chart_trace_rasterizer_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Strip chart trace rasterizer core testbench
// Streams column requests through the rasterizer and predicts the pixel runs
// that each one should produce. Every pixel that leaves the block is checked
// field by field, in order. The trace color register is rewritten between
// phases. Sender gaps and receiver stalls vary from phase to phase.
// ---------------------------------------------------------------------------
module strip_chart_trace_rasterizer_core_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 72;

  typedef struct {
    logic [sctr_pkg::COL_FIELD_W-1:0] column;
    logic [sctr_pkg::VAL_W-1:0]       value;
    logic                             present;
    logic                             rstart;
    logic                             rend;
    logic                             lpres;
    logic [sctr_pkg::VAL_W-1:0]       lval;
  } column_req_t;

  typedef struct {
    logic [sctr_pkg::COL_FIELD_W-1:0] x;
    logic [sctr_pkg::PIX_Y_W-1:0]     y;
    logic [sctr_pkg::COLOR_W-1:0]     color;
    logic                             last;
  } pixel_t;

  class trace_pixel_tracker;
    logic [sctr_pkg::COLOR_W-1:0] color;
    logic [sctr_pkg::PIX_Y_W-1:0] prev_row;
    logic                         restart;
    logic                         use_left;
    pixel_t                       pixels_due[$];
    int                           errors;

    function new();
      color = '0;
      prev_row = '0;
      restart = 1'b1;
      use_left = 1'b0;
      errors = 0;
    endfunction

    function logic [sctr_pkg::PIX_Y_W-1:0] row_of(logic [sctr_pkg::VAL_W-1:0] v);
      return sctr_pkg::PIX_Y_W'(63 - v / 4);
    endfunction

    function void push_pixel(logic [sctr_pkg::COL_FIELD_W-1:0] x, int y);
      pixel_t p;
      p.x = x;
      p.y = sctr_pkg::PIX_Y_W'(y);
      p.color = color;
      p.last = 1'b0;
      pixels_due.push_back(p);
    endfunction

    function void take_column(column_req_t c);
      logic [sctr_pkg::COL_FIELD_W-1:0] prev_x;
      logic [sctr_pkg::PIX_Y_W-1:0]     y0;
      logic [sctr_pkg::PIX_Y_W-1:0]     y1;
      logic                             start;
      int                               d;
      int                               s;
      int                               r;
      int                               base;
      prev_x = c.column - 1'b1;
      base = pixels_due.size();
      if (c.rstart) begin
        restart = 1'b1;
        use_left = c.lpres && (c.column != 0);
      end
      if (!c.present) begin
        restart = 1'b1;
        use_left = 1'b0;
        return;
      end
      start = restart;
      y1 = row_of(c.value);
      y0 = start ? row_of(use_left ? c.lval : c.value) : prev_row;
      if (y1 == y0) begin
        if (!start) push_pixel(prev_x, y0);
        if (!c.rend) push_pixel(c.column, y0);
      end else begin
        s = (y1 > y0) ? 1 : -1;
        d = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
        r = int'(y0);
        if (start) begin
          r += s * ((d + 1) / 2);
        end else begin
          for (int k = 0; k < (d + 1) / 2; k++) begin
            push_pixel(prev_x, r);
            r += s;
          end
        end
        if (!c.rend) begin
          push_pixel(c.column, r);
          for (int k = 0; k < d / 2; k++) begin
            r += s;
            push_pixel(c.column, r);
          end
        end
      end
      prev_row = y1;
      restart = 1'b0;
      use_left = 1'b0;
      if (pixels_due.size() > base) pixels_due[pixels_due.size() - 1].last = 1'b1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                   $time, got.x, got.y, got.color, got.last);
        return;
      end
      want = pixels_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 20)
          $display({"%0t: pixel mismatch expected x=%0d y=%0d color=%0d last=%0d,",
                    " got x=%0d y=%0d color=%0d last=%0d"},
                   $time, want.x, want.y, want.color, want.last,
                   got.x, got.y, got.color, got.last);
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  // column[9:0], sample_value[17:10], range_start[18], left_present[19],
  // left_value[27:20], zero pad[31:28]
  logic [sctr_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  // sample_present[0]
  logic                              in_tuser = 1'b0;
  logic                              in_tlast = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  // pixel_x[9:0], pixel_y[15:10], pixel_color[23:16]
  logic [sctr_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              out_tlast;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic                              cfg_psel = 1'b0;
  logic                              cfg_penable = 1'b0;
  logic                              cfg_pwrite = 1'b0;
  logic [sctr_pkg::APB_ADDR_W-1:0]   cfg_paddr = '0;
  logic [sctr_pkg::APB_DATA_W-1:0]   cfg_pwdata = '0;
  logic [sctr_pkg::APB_DATA_W-1:0]   cfg_prdata;
  logic                              cfg_pready;

  trace_pixel_tracker tracker;
  int   stall_mode = 0;
  logic gaps_on = 1'b0;
  int   burst_left = 0;
  logic [3:0] stall_ctr = '0;
  int   idle_cycles = 0;

  strip_chart_trace_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 1'b1;
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 2) != 0);
      end
      2: begin
        out_tready <= (stall_ctr[3:2] != 2'b11);
      end
      default: begin
        out_tready <= (stall_ctr[1:0] == 2'b00);
      end
    endcase
  end

  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[9:0];
      got.y = out_tdata[15:10];
      got.color = out_tdata[23:16];
      got.last = out_tlast;
      tracker.check_pixel(got);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic column_req_t mk_col(int col, int val, bit pres, bit rs, bit re,
                                         bit lp, int lv);
    column_req_t c;
    c.column = sctr_pkg::COL_FIELD_W'(col);
    c.value = sctr_pkg::VAL_W'(val);
    c.present = pres;
    c.rstart = rs;
    c.rend = re;
    c.lpres = lp;
    c.lval = sctr_pkg::VAL_W'(lv);
    return c;
  endfunction

  task automatic send_column(column_req_t c);
    int gap;
    if (burst_left == 0) begin
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tdata <= {{(sctr_pkg::IN_DATA_W - 28){1'b0}}, c.lval, c.lpres, c.rstart,
                 c.value, c.column};
    in_tuser <= c.present;
    in_tlast <= c.rend;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_column(c);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(logic [sctr_pkg::COLOR_W-1:0] color);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= sctr_pkg::APB_ADDR_W'(4 * sctr_pkg::REG_TRACE_COLOR);
    cfg_pwdata <= sctr_pkg::APB_DATA_W'(color);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.color = color;
  endtask

  task automatic run_random(int n_items);
    column_req_t c;
    int sent;
    int len;
    int col;
    int val;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        c = mk_col($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 255));
        send_column(c);
        sent++;
      end else begin
        len = $urandom_range(2, 12);
        col = $urandom_range(0, 1023);
        val = $urandom_range(0, 255);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 255);
            1: val = val + $urandom_range(0, 24) - 12;
            2: val = val;
            default: val = $urandom_range(0, 1) ? 255 : 0;
          endcase
          if (val < 0) val = 0;
          if (val > 255) val = 255;
          c = mk_col(col + k, val, $urandom_range(0, 9) != 0, k == 0, k == len - 1,
                     $urandom_range(0, 1), $urandom_range(0, 255));
          send_column(c);
          sent++;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_mode = 1;
    gaps_on = 1'b1;
    write_color(8'h5A);
    // left neighbor ignored at column zero, then the full-height step
    send_column(mk_col(0, 0, 1, 1, 0, 1, 255));
    send_column(mk_col(1, 255, 1, 0, 0, 0, 0));
    send_column(mk_col(2, 255, 1, 0, 0, 0, 0));
    send_column(mk_col(3, 128, 1, 0, 0, 0, 0));
    send_column(mk_col(4, 128, 0, 0, 0, 0, 0));
    send_column(mk_col(5, 100, 1, 0, 0, 0, 0));
    send_column(mk_col(6, 101, 1, 0, 0, 0, 0));
    send_column(mk_col(7, 3, 1, 0, 1, 0, 0));
    // start from the left neighbor and wrap the previous column
    send_column(mk_col(1022, 255, 1, 1, 0, 1, 0));
    send_column(mk_col(1023, 0, 1, 0, 0, 0, 0));
    send_column(mk_col(0, 77, 1, 0, 0, 0, 0));
    send_column(mk_col(1, 0, 0, 0, 1, 0, 0));
    send_column(mk_col(500, 200, 1, 1, 0, 1, 200));
    send_column(mk_col(501, 10, 1, 0, 1, 0, 0));
    // no range start: continue from the previous row
    send_column(mk_col(600, 90, 1, 0, 0, 0, 0));
    // start and end together: nothing drawn
    send_column(mk_col(601, 255, 1, 1, 1, 0, 255));
    // absent sample drops the left neighbor
    send_column(mk_col(700, 40, 0, 1, 0, 1, 255));
    send_column(mk_col(701, 0, 1, 0, 0, 0, 0));
    send_column(mk_col(702, 255, 1, 0, 1, 0, 0));
    send_column(mk_col(703, 128, 1, 0, 0, 1, 0));
    send_column(mk_col(704, 252, 1, 1, 0, 1, 3));
    send_column(mk_col(705, 252, 1, 0, 1, 1, 3));
    drain();

    for (int p = 0; p < 4; p++) begin
      stall_mode = p;
      gaps_on = (p != 0);
      case (p)
        0: write_color(8'h00);
        1: write_color(8'hFF);
        default: write_color(sctr_pkg::COLOR_W'($urandom_range(1, 254)));
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/sctr_pkg.sv
design/sctr_regs.sv
design/sctr_ctrl.sv
design/sctr_datapath.sv
design/strip_chart_trace_rasterizer_core.sv
dv/strip_chart_trace_rasterizer_core_tb.sv
